>>> rtl/enbm_pkg.sv
`default_nettype none
package enbm_pkg;
	localparam int MaxWidth   = 1024;
	localparam int SampleBits = 16;
	localparam int FracBits   = 8;
	localparam int ColBits    = $clog2(MaxWidth);
	localparam int RowBits    = 12;
	localparam int WidthBits  = 11;
	localparam int OutBits    = SampleBits + FracBits;
	localparam int SumBits    = SampleBits + 4;
	localparam int QueueDepth = 4;
	localparam int QueueBits  = $clog2(QueueDepth);
	localparam int AddrBits   = 3;

	localparam logic [AddrBits-1:0] AddrWidth  = 3'd0;
	localparam logic [AddrBits-1:0] AddrHeight = 3'd4;

	localparam logic OpPixel = 1'b0;
	localparam logic OpFlush = 1'b1;

	typedef logic signed [SampleBits-1:0] sample_t;

	// one accepted column shift, classified by the front part
	typedef struct packed {
		sample_t        px;
		logic [ColBits-1:0] col;
		logic           due;
		logic           has_left;
		logic           has_right;
		logic           has_up;
		logic           has_down;
		logic           last;
	} job_t;

	typedef enum logic [1:0] {
		DivIdle,
		DivRun,
		DivDone
	} div_state_t;
endpackage
`default_nettype wire

>>> rtl/enbm_if.sv
`default_nettype none
interface enbm_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic signed [enbm_pkg::SampleBits-1:0] pixel;
	modport source (output valid, operation, pixel, input ready);
	modport sink (input valid, operation, pixel, output ready);
endinterface

interface enbm_out_if;
	logic valid;
	logic ready;
	logic signed [enbm_pkg::OutBits-1:0] mean_value;
	logic [3:0] neighbour_count;
	logic last_of_frame;
	modport source (output valid, mean_value, neighbour_count, last_of_frame, input ready);
	modport sink (input valid, mean_value, neighbour_count, last_of_frame, output ready);
endinterface
`default_nettype wire

>>> rtl/enbm_front.sv
`default_nettype none
module enbm_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic clear,
	input  wire logic [enbm_pkg::WidthBits-1:0] frame_width,
	input  wire logic [enbm_pkg::RowBits-1:0] frame_height,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic in_op,
	input  wire logic [enbm_pkg::SampleBits-1:0] in_pixel,
	input  wire logic q_ready,
	output logic q_valid,
	output enbm_pkg::job_t q_job
);
	import enbm_pkg::*;

	logic [ColBits-1:0] in_col_q, out_col_q;
	logic [RowBits:0] in_row_q, out_row_q;
	logic [WidthBits-1:0] w;
	logic [RowBits-1:0] h;
	logic accept_ok, fire, due, last;

	always_comb begin
		w = (frame_width == '0) ? WidthBits'(1) : frame_width;
		if (w > WidthBits'(MaxWidth)) w = WidthBits'(MaxWidth);
		h = (frame_height == '0) ? RowBits'(1) : frame_height;
	end

	// pixels valid while rows remain, flushes only after the frame
	assign accept_ok = (in_op == OpPixel) ? (in_row_q < {1'b0, h}) : (in_row_q >= {1'b0, h});
	assign in_ready = q_ready;
	assign fire = in_valid && q_ready && accept_ok;
	assign due = (in_row_q >= 2) || (in_row_q == 1 && in_col_q != '0);
	assign last = ({1'b0, out_row_q} + 1 >= {2'b0, h}) &&
		({1'b0, out_col_q} + 1 >= {1'b0, w});

	always_comb begin
		q_valid = fire;
		q_job.px = (in_op == OpPixel) ? in_pixel : '0;
		q_job.col = in_col_q;
		q_job.due = due;
		q_job.has_left = out_col_q != '0;
		q_job.has_right = ({1'b0, out_col_q} + 1) < {1'b0, w};
		q_job.has_up = out_row_q != '0;
		q_job.has_down = ({1'b0, out_row_q} + 1) < {2'b0, h};
		q_job.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (clear) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (fire) begin
			if (due && last) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if ({1'b0, in_col_q} + 1 >= {1'b0, w}) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1;
				end else begin
					in_col_q <= in_col_q + 1;
				end
				if (due) begin
					if ({1'b0, out_col_q} + 1 >= {1'b0, w}) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1;
					end else begin
						out_col_q <= out_col_q + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/enbm_queue.sv
`default_nettype none
module enbm_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic wr_ready,
	input  wire enbm_pkg::job_t wr_job,
	output logic rd_valid,
	input  wire logic rd_ready,
	output enbm_pkg::job_t rd_job
);
	import enbm_pkg::*;

	job_t mem_q [QueueDepth];
	logic [QueueBits-1:0] wp_q, rp_q;
	logic [QueueBits:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != (QueueBits+1)'(QueueDepth);
	assign rd_valid = cnt_q != '0;
	assign rd_job = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1;
			if (pop) rp_q <= rp_q + 1;
			cnt_q <= cnt_q + (QueueBits+1)'(push) - (QueueBits+1)'(pop);
		end
	end
endmodule
`default_nettype wire

>>> rtl/enbm_back.sv
`default_nettype none
module enbm_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic q_ready,
	input  wire enbm_pkg::job_t q_job,
	output logic o_valid,
	input  wire logic o_ready,
	output logic [enbm_pkg::OutBits-1:0] o_mean,
	output logic [3:0] o_count,
	output logic o_last
);
	import enbm_pkg::*;

	localparam int DivBits = SumBits + FracBits;
	localparam int StepBits = $clog2(DivBits + 1);

	sample_t upper_mem_q [MaxWidth];
	sample_t middle_mem_q [MaxWidth];
	sample_t win_q [9];
	sample_t up_s1, mid_s1;

	div_state_t state_q, state_d;
	logic job_s1;
	job_t job_hold_s1;
	logic signed [SumBits-1:0] sum;
	logic [3:0] cnt;
	logic neg_q, last_q;
	logic [3:0] cnt_q;
	logic [DivBits-1:0] num_q;
	logic [4:0] rem_q;
	logic [StepBits-1:0] step_q;
	logic [4:0] rem_sh;
	logic [DivBits-1:0] quo;
	logic [OutBits-1:0] res_q;
	logic res_valid_q;
	logic start;

	// stage 1 reads line stores; a new job enters only when the divider is free
	assign q_ready = !job_s1 && state_q == DivIdle;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			up_s1 <= upper_mem_q[q_job.col];
			mid_s1 <= middle_mem_q[q_job.col];
			job_hold_s1 <= q_job;
			upper_mem_q[q_job.col] <= middle_mem_q[q_job.col];
			middle_mem_q[q_job.col] <= q_job.px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_s1 <= 1'b0;
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else begin
			job_s1 <= q_valid && q_ready;
			if (job_s1) begin
				for (int k = 0; k < 6; k++) win_q[k] <= win_q[k+3];
				win_q[6] <= up_s1;
				win_q[7] <= mid_s1;
				win_q[8] <= job_hold_s1.px;
			end
		end
	end

	// neighbourhood sum over the shifted window
	always_comb begin
		sample_t nw [9];
		for (int k = 0; k < 6; k++) nw[k] = win_q[k+3];
		nw[6] = up_s1;
		nw[7] = mid_s1;
		nw[8] = job_hold_s1.px;
		sum = '0;
		cnt = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (!(c == 0 && !job_hold_s1.has_left) && !(c == 2 && !job_hold_s1.has_right) &&
					!(r == 0 && !job_hold_s1.has_up) && !(r == 2 && !job_hold_s1.has_down)) begin
					sum = sum + SumBits'(nw[c*3+r]);
					cnt = cnt + 4'd1;
				end
			end
		end
	end

	assign start = job_s1 && job_hold_s1.due;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DivIdle: if (start) state_d = DivRun;
			DivRun: if (step_q == StepBits'(1)) state_d = DivDone;
			DivDone: if (!res_valid_q || o_ready) state_d = DivIdle;
			default: state_d = DivIdle;
		endcase
	end

	// restoring division of |sum| << frac, one quotient bit per cycle
	assign rem_sh = {rem_q[3:0], num_q[DivBits-1]};
	assign quo = neg_q ? (~num_q + 1'b1) : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DivIdle;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == DivDone && (!res_valid_q || o_ready)) res_valid_q <= 1'b1;
			else if (o_valid && o_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DivIdle: if (start) begin
				neg_q <= sum[SumBits-1];
				num_q <= DivBits'(sum[SumBits-1] ? -sum : sum) << FracBits;
				rem_q <= '0;
				cnt_q <= cnt;
				last_q <= job_hold_s1.last;
				step_q <= StepBits'(DivBits);
			end
			DivRun: begin
				if (rem_sh >= {1'b0, cnt_q}) begin
					rem_q <= rem_sh - {1'b0, cnt_q};
					num_q <= {num_q[DivBits-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					num_q <= {num_q[DivBits-2:0], 1'b0};
				end
				step_q <= step_q - 1'b1;
			end
			DivDone: if (!res_valid_q || o_ready) begin
				res_q <= OutBits'(quo);
				o_count <= cnt_q;
				o_last <= last_q;
			end
			default: ;
		endcase
	end

	assign o_valid = res_valid_q;
	assign o_mean = res_q;
endmodule
`default_nettype wire

>>> rtl/edge_normalized_box_mean_3x3.sv
// channel | dir | payload
// in      | in  | operation, pixel (16 bit signed)
// out     | out | mean_value (24 bit), neighbour_count, last_of_frame
// cfg     | in  | apb, 0x0 frame_width, 0x4 frame_height
// the front part takes an item per cycle into a 4 deep job queue while the queue has room
// the back part handles one result at a time: line store read, window and sum,
// 28 serial divider steps, then a load of the result register
// items without a result only update the line stores and the window in the back part
// arst_n clears positions, window and control; line stores hold junk until written
// out stalls hold the result register, which backs up the queue and then in
`default_nettype none
module edge_normalized_box_mean_3x3 (
	input  wire logic clk,
	input  wire logic arst_n,
	enbm_in_if.sink in_ch,
	enbm_out_if.source out_ch,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [enbm_pkg::AddrBits-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import enbm_pkg::*;

	logic [WidthBits-1:0] width_q;
	logic [RowBits-1:0] height_q;
	logic wr_en;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	job_t fq_job, bq_job;
	logic [OutBits-1:0] mean;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// register file; a write to frame_width or frame_height also restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WidthBits'(64);
			height_q <= RowBits'(64);
		end else if (wr_en) begin
			unique case (paddr)
				AddrWidth: width_q <= pwdata[WidthBits-1:0];
				AddrHeight: height_q <= pwdata[RowBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			AddrWidth: prdata = 32'(width_q);
			AddrHeight: prdata = 32'(height_q);
			default: prdata = '0;
		endcase
	end

	enbm_front u_front (
		.clk, .arst_n,
		.clear(wr_en && (paddr == AddrWidth || paddr == AddrHeight)),
		.frame_width(width_q), .frame_height(height_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_op(in_ch.operation), .in_pixel(in_ch.pixel),
		.q_ready(fq_ready), .q_valid(fq_valid), .q_job(fq_job)
	);

	enbm_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_job(bq_job)
	);

	enbm_back u_back (
		.clk, .arst_n,
		.q_valid(bq_valid), .q_ready(bq_ready), .q_job(bq_job),
		.o_valid(out_ch.valid), .o_ready(out_ch.ready),
		.o_mean(mean), .o_count(out_ch.neighbour_count), .o_last(out_ch.last_of_frame)
	);

	assign out_ch.mean_value = mean;
endmodule
`default_nettype wire

>>> rtl/enbm_checker.sv
`default_nettype none
module enbm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [3:0] out_count,
	input wire logic pready
);
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count >= 4'd1 && out_count <= 4'd9)) else $error("bad count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready) else $error("pready low");
endmodule

bind edge_normalized_box_mean_3x3 enbm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_count(out_ch.neighbour_count), .pready(pready)
);
`default_nettype wire
